/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// every macro expects signals named clk and rst in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ggbfs_pkg.sv */
// shared types, codes and helpers for the grid best-first step unit
// no dependencies
package ggbfs_pkg;

  localparam int COORD_W = 4;
  localparam int DIST_W  = 5;
  localparam int CFG_W   = 5;
  localparam int CFG_AW  = 3;
  localparam int ENTRY_W = 2 * COORD_W + DIST_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;
  typedef logic [CFG_AW-1:0]  cfg_addr_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_RESTART = 2'd1,
    OP_STEP    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_MOVED  = 2'd0,
    STAT_GOAL   = 2'd1,
    STAT_NOPATH = 2'd2,
    STAT_ACK    = 2'd3
  } status_t;

  localparam cfg_addr_t REG_GRID_COLS = 3'd0;
  localparam cfg_addr_t REG_GRID_ROWS = 3'd1;
  localparam cfg_addr_t REG_START_X   = 3'd2;
  localparam cfg_addr_t REG_START_Y   = 3'd3;
  localparam cfg_addr_t REG_GOAL_X    = 3'd4;
  localparam cfg_addr_t REG_GOAL_Y    = 3'd5;

  localparam cfg_data_t RST_GRID_COLS = 5'd12;
  localparam cfg_data_t RST_GRID_ROWS = 5'd12;
  localparam coord_t    RST_START_X   = 4'd1;
  localparam coord_t    RST_START_Y   = 4'd3;
  localparam coord_t    RST_GOAL_X    = 4'd9;
  localparam coord_t    RST_GOAL_Y    = 4'd9;

  typedef struct packed {
    coord_t x;
    coord_t y;
    dist_t  d;
  } entry_t;

  function automatic logic [DIST_W-1:0] gap5(input logic [4:0] a, input logic [4:0] b);
    gap5 = (a > b) ? (a - b) : (b - a);
  endfunction

  // manhattan distance, wrapped to the field width
  function automatic dist_t manhattan(input logic [4:0] x, input logic [4:0] y,
                                      input coord_t gx, input coord_t gy);
    logic [DIST_W:0] s;
    s = {1'b0, gap5(x, {1'b0, gx})} + {1'b0, gap5(y, {1'b0, gy})};
    manhattan = s[DIST_W-1:0];
  endfunction

endpackage

/* hw/rtl/grid_greedy_best_first_step_unit.sv */
// greedy best-first search step unit on a 4-connected grid, manhattan heuristic
// depends on ggbfs_pkg, ggbfs_ram and assert_macros.svh
// write and unknown ops and a step at the goal answer straight from idle; a restart
//   runs a clearing pass over the discovered map; a step walks the single queue ram
//   port once for the min search and once for the close-up
// throughput: one item at a time, busy is high until the result strobe
// reset: synchronous, then a clearing pass over both maps with busy high; the result
//   receiver cannot stall, done lasts one cycle
`include "assert_macros.svh"

module grid_greedy_best_first_step_unit #(
  parameter int GRID_SIDE  = 16,
  parameter int OPEN_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  ggbfs_pkg::opcode_t   opcode,
  input  ggbfs_pkg::coord_t    cell_x,
  input  ggbfs_pkg::coord_t    cell_y,
  input  logic                 blocked,
  // configuration writes
  input  logic                 cfg_wen,
  input  ggbfs_pkg::cfg_addr_t cfg_addr,
  input  ggbfs_pkg::cfg_data_t cfg_wdata,
  // results
  output logic                 done,
  output ggbfs_pkg::coord_t    pos_x,
  output ggbfs_pkg::coord_t    pos_y,
  output ggbfs_pkg::dist_t     distance,
  output ggbfs_pkg::status_t   status
);
  import ggbfs_pkg::*;

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int MAP_AW = $clog2(CELLS);
  localparam int QAW    = $clog2(OPEN_DEPTH);
  localparam int SPAN_W = $clog2(GRID_SIDE + 1) + 1;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CLEAR    = 8'b0000_0010,
    S_MARK     = 8'b0000_0100,
    S_NB_ADDR  = 8'b0000_1000,
    S_NB_CHECK = 8'b0001_0000,
    S_SCAN     = 8'b0010_0000,
    S_SHIFT    = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t          state;
  logic            clr_all;      // reset sweep also clears the blocked map
  logic [MAP_AW-1:0] clr_idx;

  // configuration registers
  cfg_data_t grid_cols, grid_rows;
  coord_t    start_x, start_y, goal_x, goal_y;

  // search state
  coord_t        cur_x, cur_y;
  logic [QAW:0]  open_count;
  logic [1:0]    nb;             // neighbor order: +x, -y, -x, +y
  status_t       st;

  // shared queue walker: issue index, then compare/move in the next cycle
  logic [QAW:0]   qi;
  logic           pv;
  logic [QAW-1:0] pidx;
  logic [QAW-1:0] best_idx;
  entry_t         best_e;

  // ram ports
  logic              blk_we, disc_we, disc_wdata, q_we;
  logic [MAP_AW-1:0] blk_waddr, disc_waddr, map_raddr;
  logic              blk_wdata;
  logic              blk_q, disc_q;
  logic [QAW-1:0]    q_waddr, q_raddr;
  entry_t            q_wdata, q_rdata;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // usable grid span, zero acts as one and oversize clamps to storage
  logic [SPAN_W-1:0] span_c, span_r;
  always_comb begin
    if (grid_cols == '0) begin
      span_c = SPAN_W'(1);
    end else if (32'(grid_cols) > GRID_SIDE) begin
      span_c = SPAN_W'(GRID_SIDE);
    end else begin
      span_c = SPAN_W'(grid_cols);
    end
    if (grid_rows == '0) begin
      span_r = SPAN_W'(1);
    end else if (32'(grid_rows) > GRID_SIDE) begin
      span_r = SPAN_W'(GRID_SIDE);
    end else begin
      span_r = SPAN_W'(grid_rows);
    end
  end

  // neighbor coordinates for the current slot
  logic [4:0] nx, ny;
  logic       nneg, nb_in, nb_free;
  always_comb begin
    nx   = {1'b0, cur_x};
    ny   = {1'b0, cur_y};
    nneg = 1'b0;
    unique case (nb)
      2'd0: nx = {1'b0, cur_x} + 5'd1;
      2'd1: begin
        ny   = {1'b0, cur_y} - 5'd1;
        nneg = (cur_y == '0);
      end
      2'd2: begin
        nx   = {1'b0, cur_x} - 5'd1;
        nneg = (cur_x == '0);
      end
      default: ny = {1'b0, cur_y} + 5'd1;
    endcase
    nb_in   = !nneg && (32'(nx) < 32'(span_c)) && (32'(ny) < 32'(span_r));
    nb_free = !blk_q && !disc_q && (32'(open_count) < OPEN_DEPTH);
  end

  logic cur_stored, cell_stored, at_goal;
  assign cur_stored  = (32'(cur_x) < GRID_SIDE) && (32'(cur_y) < GRID_SIDE);
  assign cell_stored = (32'(cell_x) < GRID_SIDE) && (32'(cell_y) < GRID_SIDE);
  assign at_goal     = (cur_x == goal_x) && (cur_y == goal_y);

  // row-major cell address
  logic [MAP_AW-1:0] nb_idx, cur_idx, cell_idx;
  assign nb_idx   = MAP_AW'(32'(ny) * GRID_SIDE + 32'(nx));
  assign cur_idx  = MAP_AW'(32'(cur_y) * GRID_SIDE + 32'(cur_x));
  assign cell_idx = MAP_AW'(32'(cell_y) * GRID_SIDE + 32'(cell_x));

  // ram control
  always_comb begin
    blk_we     = 1'b0;
    blk_waddr  = cell_idx;
    blk_wdata  = blocked;
    disc_we    = 1'b0;
    disc_waddr = nb_idx;
    disc_wdata = 1'b1;
    map_raddr  = nb_idx;
    q_we       = 1'b0;
    q_waddr    = open_count[QAW-1:0];
    q_wdata    = '{x: nx[COORD_W-1:0], y: ny[COORD_W-1:0],
                   d: manhattan(nx, ny, goal_x, goal_y)};
    q_raddr    = qi[QAW-1:0];
    unique case (state)
      S_CLEAR: begin
        disc_we    = 1'b1;
        disc_waddr = clr_idx;
        disc_wdata = 1'b0;
        blk_we     = clr_all;
        blk_waddr  = clr_idx;
        blk_wdata  = 1'b0;
      end
      S_IDLE: begin
        blk_we = accept && (opcode == OP_WRITE) && cell_stored;
      end
      S_MARK: begin
        disc_we    = cur_stored;
        disc_waddr = cur_idx;
      end
      S_NB_CHECK: begin
        disc_we = nb_free;
        q_we    = nb_free;
      end
      S_SHIFT: begin
        // close the gap: entry at pidx moves down one
        q_we    = pv;
        q_waddr = pidx - QAW'(1);
        q_wdata = q_rdata;
      end
      default: ;
    endcase
  end

  ggbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk_map (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(map_raddr), .rdata(blk_q)
  );

  ggbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_disc_map (
    .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
    .raddr(map_raddr), .rdata(disc_q)
  );

  ggbfs_ram #(.WIDTH(ENTRY_W), .DEPTH(OPEN_DEPTH)) u_open_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // min-search compare: strict less keeps the earliest entry on a tie
  logic           take;
  logic [QAW-1:0] sel_idx, last_idx;
  entry_t         sel_e;
  assign take     = (pidx == '0) || (q_rdata.d < best_e.d);
  assign sel_idx  = take ? pidx : best_idx;
  assign sel_e    = take ? q_rdata : best_e;
  assign last_idx = QAW'(open_count - (QAW + 1)'(1));

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= RST_GRID_COLS;
      grid_rows <= RST_GRID_ROWS;
      start_x   <= RST_START_X;
      start_y   <= RST_START_Y;
      goal_x    <= RST_GOAL_X;
      goal_y    <= RST_GOAL_Y;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_GRID_COLS: grid_cols <= cfg_wdata;
        REG_GRID_ROWS: grid_rows <= cfg_wdata;
        REG_START_X:   start_x   <= cfg_wdata[COORD_W-1:0];
        REG_START_Y:   start_y   <= cfg_wdata[COORD_W-1:0];
        REG_GOAL_X:    goal_x    <= cfg_wdata[COORD_W-1:0];
        REG_GOAL_Y:    goal_y    <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_all    <= 1'b1;
      clr_idx    <= '0;
      cur_x      <= RST_START_X;
      cur_y      <= RST_START_Y;
      open_count <= '0;
      done       <= 1'b0;
      nb         <= '0;
      st         <= STAT_ACK;
      qi         <= '0;
      pv         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // default: answer right away with the position unchanged
            pos_x    <= cur_x;
            pos_y    <= cur_y;
            distance <= manhattan({1'b0, cur_x}, {1'b0, cur_y}, goal_x, goal_y);
            status   <= STAT_ACK;
            priority case (opcode)
              OP_RESTART: begin
                cur_x      <= start_x;
                cur_y      <= start_y;
                open_count <= '0;
                clr_all    <= 1'b0;
                clr_idx    <= '0;
                st         <= STAT_ACK;
                state      <= S_CLEAR;
              end
              OP_STEP: begin
                if (at_goal) begin
                  status <= STAT_GOAL;
                  done   <= 1'b1;
                end else begin
                  state <= S_MARK;
                end
              end
              default: done <= 1'b1;  // write and unknown ops acknowledge
            endcase
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + MAP_AW'(1);
          if (clr_idx == MAP_AW'(CELLS - 1)) begin
            state <= clr_all ? S_IDLE : S_FINISH;
          end
        end
        S_MARK: begin
          nb    <= '0;
          state <= S_NB_ADDR;
        end
        S_NB_ADDR: begin
          if (nb_in) begin
            state <= S_NB_CHECK;
          end else if (nb == 2'd3) begin
            qi    <= '0;
            pv    <= 1'b0;
            state <= S_SCAN;
          end else begin
            nb <= nb + 2'd1;
          end
        end
        S_NB_CHECK: begin
          if (nb_free) begin
            open_count <= open_count + (QAW + 1)'(1);
          end
          if (nb == 2'd3) begin
            qi    <= '0;
            pv    <= 1'b0;
            state <= S_SCAN;
          end else begin
            nb    <= nb + 2'd1;
            state <= S_NB_ADDR;
          end
        end
        S_SCAN: begin
          if (open_count == '0) begin
            st    <= STAT_NOPATH;
            state <= S_FINISH;
          end else begin
            pv   <= (qi < open_count);
            pidx <= qi[QAW-1:0];
            if (qi < open_count) begin
              qi <= qi + (QAW + 1)'(1);
            end
            if (pv) begin
              best_idx <= sel_idx;
              best_e   <= sel_e;
            end
            if (pv && (pidx == last_idx)) begin
              // winner found, move there and close its slot
              cur_x <= sel_e.x;
              cur_y <= sel_e.y;
              st    <= STAT_MOVED;
              if (sel_idx == last_idx) begin
                open_count <= open_count - (QAW + 1)'(1);
                state      <= S_FINISH;
              end else begin
                qi    <= (QAW + 1)'(sel_idx) + (QAW + 1)'(1);
                pv    <= 1'b0;
                state <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          pv   <= (qi < open_count);
          pidx <= qi[QAW-1:0];
          if (qi < open_count) begin
            qi <= qi + (QAW + 1)'(1);
          end
          if (pv && (pidx == last_idx)) begin
            open_count <= open_count - (QAW + 1)'(1);
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          done     <= 1'b1;
          pos_x    <= cur_x;
          pos_y    <= cur_y;
          distance <= manhattan({1'b0, cur_x}, {1'b0, cur_y}, goal_x, goal_y);
          status   <= ((st == STAT_MOVED) && at_goal) ? STAT_GOAL : st;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `CHK_ALWAYS(a_count_bound, 32'(open_count) <= OPEN_DEPTH, "open queue overfilled")
  `CHK_NEXT(a_step_reacts, accept && (opcode == OP_STEP), busy || done, "step item dropped")
  `CHK_IMPLY(a_shift_in_range, state == S_SHIFT, (QAW + 1)'(best_idx) < open_count, "bad pop slot")
  `CHK_IMPLY(a_nopath_empty, done && (status == STAT_NOPATH), open_count == '0, "no path with queue left")

endmodule

/* hw/rtl/ggbfs_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ggbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* tb/grid_greedy_best_first_step_unit_checker.sv */
// checker for the grid best-first step unit: predicts each result and compares it
// depends on ggbfs_pkg
module grid_greedy_best_first_step_unit_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  ggbfs_pkg::opcode_t   opcode,
  input  ggbfs_pkg::coord_t    cell_x,
  input  ggbfs_pkg::coord_t    cell_y,
  input  logic                 blocked,
  input  logic                 cfg_wen,
  input  ggbfs_pkg::cfg_addr_t cfg_addr,
  input  ggbfs_pkg::cfg_data_t cfg_wdata,
  input  logic                 done,
  input  ggbfs_pkg::coord_t    pos_x,
  input  ggbfs_pkg::coord_t    pos_y,
  input  ggbfs_pkg::dist_t     distance,
  input  ggbfs_pkg::status_t   status,
  output int                   fail_count,
  output int                   pending_count
);
  import ggbfs_pkg::*;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    dist_t   d;
    status_t st;
  } step_result_t;

  bit         wall [256];
  bit         seen [256];
  entry_t     frontier [256];
  int         frontier_len;
  int         here_x, here_y;
  int         cols, rows, sx, sy, gx, gy;
  step_result_t result_q[$];

  function automatic int span(int r);
    if (r == 0) return 1;
    if (r > 16) return 16;
    return r;
  endfunction

  function automatic dist_t goal_dist(int x, int y);
    int s;
    s = (x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y);
    return dist_t'(s & 31);
  endfunction

  function automatic void visit(int nx, int ny);
    int k;
    if (nx < 0 || ny < 0 || nx >= span(cols) || ny >= span(rows)) return;
    k = ny * 16 + nx;
    if (wall[k] || seen[k] || frontier_len >= 256) return;
    seen[k] = 1;
    frontier[frontier_len] = '{x: coord_t'(nx), y: coord_t'(ny), d: goal_dist(nx, ny)};
    frontier_len++;
  endfunction

  function automatic status_t advance();
    int best;
    entry_t e;
    if (here_x == gx && here_y == gy) return STAT_GOAL;
    seen[here_y * 16 + here_x] = 1;
    visit(here_x + 1, here_y);
    visit(here_x, here_y - 1);
    visit(here_x - 1, here_y);
    visit(here_x, here_y + 1);
    if (frontier_len == 0) return STAT_NOPATH;
    best = 0;
    for (int i = 1; i < frontier_len; i++)
      if (frontier[i].d < frontier[best].d) best = i;
    e = frontier[best];
    for (int i = best; i + 1 < frontier_len; i++) frontier[i] = frontier[i + 1];
    frontier_len--;
    here_x = e.x;
    here_y = e.y;
    return (here_x == gx && here_y == gy) ? STAT_GOAL : STAT_MOVED;
  endfunction

  function automatic void predict(opcode_t op, coord_t cx, coord_t cy, logic bl);
    status_t st;
    st = STAT_ACK;
    case (op)
      OP_WRITE: wall[cy * 16 + cx] = bl;
      OP_RESTART: begin
        foreach (seen[i]) seen[i] = 0;
        frontier_len = 0;
        here_x = sx;
        here_y = sy;
      end
      OP_STEP: st = advance();
      default: ;
    endcase
    result_q.push_back('{x: coord_t'(here_x), y: coord_t'(here_y),
                         d: goal_dist(here_x, here_y), st: st});
  endfunction

  assign pending_count = result_q.size();

  always @(posedge clk) begin
    step_result_t exp_r;
    if (rst) begin
      foreach (wall[i]) begin
        wall[i] = 0;
        seen[i] = 0;
      end
      frontier_len = 0;
      cols = RST_GRID_COLS; rows = RST_GRID_ROWS;
      sx = RST_START_X; sy = RST_START_Y;
      gx = RST_GOAL_X; gy = RST_GOAL_Y;
      here_x = sx; here_y = sy;
      result_q.delete();
      fail_count = 0;
    end else begin
      // compare first, the result of a transfer never lands in the same cycle
      if (done) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (pos_x !== exp_r.x) begin
            $error("pos_x expected %0d actual %0d", exp_r.x, pos_x); fail_count++;
          end
          if (pos_y !== exp_r.y) begin
            $error("pos_y expected %0d actual %0d", exp_r.y, pos_y); fail_count++;
          end
          if (distance !== exp_r.d) begin
            $error("distance expected %0d actual %0d", exp_r.d, distance); fail_count++;
          end
          if (status !== exp_r.st) begin
            $error("status expected %0d actual %0d", exp_r.st, status); fail_count++;
          end
        end
      end
      if (cfg_wen) begin
        case (cfg_addr)
          REG_GRID_COLS: cols = cfg_wdata;
          REG_GRID_ROWS: rows = cfg_wdata;
          REG_START_X:   sx = cfg_wdata[3:0];
          REG_START_Y:   sy = cfg_wdata[3:0];
          REG_GOAL_X:    gx = cfg_wdata[3:0];
          REG_GOAL_Y:    gy = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (start && !busy) predict(opcode, cell_x, cell_y, blocked);
    end
  end
endmodule

/* tb/grid_greedy_best_first_step_unit_tb.sv */
// testbench top for the grid best-first step unit: stimulus and verdict
// depends on ggbfs_pkg, the block and grid_greedy_best_first_step_unit_checker
module grid_greedy_best_first_step_unit_tb;
  import ggbfs_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  logic      clk = 0;
  logic      rst = 1;
  logic      start = 0;
  logic      busy;
  opcode_t   opcode = OP_WRITE;
  coord_t    cell_x = '0;
  coord_t    cell_y = '0;
  logic      blocked = 0;
  logic      cfg_wen = 0;
  cfg_addr_t cfg_addr = REG_GRID_COLS;
  cfg_data_t cfg_wdata = '0;
  logic      done;
  coord_t    pos_x, pos_y;
  dist_t     distance;
  status_t   status;
  int        fail_count, pending_count;
  int        cycle_count = 0;
  int        idle_pct = 0;   // chance in a hundred that the sender sits out a cycle

  always #2 clk = ~clk;

  grid_greedy_best_first_step_unit i_dut (.*);

  grid_greedy_best_first_step_unit_checker i_chk (.*);

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one command transfer; start is held until the block takes it and stays
  // high on return so a following transfer can come back to back
  task automatic send(opcode_t op, coord_t x = '0, coord_t y = '0, logic bl = 0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    opcode <= op;
    cell_x <= x;
    cell_y <= y;
    blocked <= bl;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every predicted result has come, then let a tail pass
  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (pending_count != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_addr_t a, cfg_data_t v);
    cfg_wen <= 1;
    cfg_addr <= a;
    cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic set_grid(int c, int r, int s_x, int s_y, int g_x, int g_y);
    drain();
    write_reg(REG_GRID_COLS, cfg_data_t'(c));
    write_reg(REG_GRID_ROWS, cfg_data_t'(r));
    write_reg(REG_START_X, cfg_data_t'(s_x));
    write_reg(REG_START_Y, cfg_data_t'(s_y));
    write_reg(REG_GOAL_X, cfg_data_t'(g_x));
    write_reg(REG_GOAL_Y, cfg_data_t'(g_y));
    cfg_wen <= 0;
  endtask

  // random obstacles then a restart and a run of steps, with a random command now and then
  task automatic search_run(int n_walls, int n_steps);
    repeat (n_walls) send(OP_WRITE, coord_t'($urandom), coord_t'($urandom),
                          ($urandom_range(99) < 70));
    send(OP_RESTART);
    repeat (n_steps) begin
      if ($urandom_range(99) < 4) send(opcode_t'($urandom_range(3)), coord_t'($urandom),
                                       coord_t'($urandom), 1'($urandom));
      else send(OP_STEP);
    end
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset settings, corner cells, opcodes, goal and dead ends
    send(OP_STEP);
    send(OP_NONE, 4'hf, 4'hf, 1);
    send(OP_WRITE, 4'hf, 4'hf, 1);
    send(OP_WRITE, 4'h0, 4'h0, 0);
    send(OP_WRITE, 4'h2, 4'h3, 1);
    repeat (6) send(OP_STEP);
    send(OP_RESTART);
    send(OP_WRITE, 4'h2, 4'h3, 0);
    // one by one grid: start equals goal, then no path
    set_grid(0, 0, 0, 0, 0, 0);
    send(OP_RESTART);
    send(OP_STEP);
    set_grid(1, 1, 0, 0, 15, 15);
    send(OP_RESTART);
    send(OP_STEP);
    send(OP_STEP);
    // full 16x16 and oversize values, start outside grid in use
    set_grid(31, 20, 15, 15, 0, 0);
    send(OP_RESTART);
    repeat (4) send(OP_STEP);
    set_grid(4, 4, 9, 9, 0, 15);
    send(OP_RESTART);
    repeat (3) send(OP_STEP);

    // random phases over several settings, each with its own idle level
    sent = 0;
    for (int ph = 0; sent < 1750; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 79 : 18;
      if (ph % 5 == 0) set_grid(16, 16, $urandom_range(15), $urandom_range(15),
                                $urandom_range(15), $urandom_range(15));
      else set_grid($urandom_range(31), $urandom_range(31), $urandom_range(15),
                    $urandom_range(15), $urandom_range(15), $urandom_range(15));
      // six search runs per phase; every fourth phase clears walls so maps do not saturate
      for (int k = 0; k < 6; k++) begin
        int nw, ns;
        nw = $urandom_range(12);
        ns = $urandom_range(5, 40);
        search_run(nw, ns);
        sent += nw + ns + 1;
      end
      if (ph % 4 == 3) begin
        for (int c = 0; c < 256; c += 1 + $urandom_range(2)) begin
          send(OP_WRITE, coord_t'(c % 16), coord_t'(c / 16), 0);
          sent++;
        end
      end
    end

    drain();
    repeat (600) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
